// ===== rtl/grdfs_pkg.sv =====
// ----------------------------------------------------------------------------
// grdfs_pkg: shared definitions for the graph reachability search block
// Field widths, item mode codes, register indexes and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package grdfs_pkg;

	localparam int MAX_VERTICES_DEF = 64;

	localparam int MODE_W     = 2;
	localparam int VTX_W      = 6;
	localparam int CNT_W      = 7;
	localparam int MASK_W     = 64;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VERTEX = 1'b1;

	localparam logic [CNT_W-1:0] VERTEX_COUNT_RST  = 7'd64;
	localparam logic [VTX_W-1:0] SOURCE_VERTEX_RST = 6'd0;

	typedef struct packed {
		logic start_add;
		logic start_clear;
		logic start_run;
		logic add_write;
		logic adj_load;
		logic push;
		logic pop;
		logic stk_read;
		logic load_out;
	} grdfs_cmd_t;

	typedef struct packed {
		logic add_drop;
		logic src_bad;
		logic fresh_zero;
		logic depth_zero;
		logic out_free;
	} grdfs_status_t;

endpackage

// ===== rtl/graph_reachability_dfs_top.sv =====
// ----------------------------------------------------------------------------
// graph_reachability_dfs_top: graph reachability by depth-first search
// Adjacency bit matrix loading and stack-based search from a source vertex.
// ----------------------------------------------------------------------------
// Items are taken one at a time. An add item that is stored is read and
// written back (one adjacency row) through the ADD_WR state; a dropped add,
// a clear item and an unused mode are taken in the idle state alone.
// A run item with a valid source walks each reached vertex in turn: a stack
// RAM read, an adjacency RAM read and a push for each newly found
// neighbour; an invalid source goes straight to the finish state. The item
// channel stalls for the whole run. The result waits in an output register,
// so adds and clears are taken while it is stalled; a following run finishes
// only once that result has left. The matrix clears through per-row valid
// bits; no clearing pass is needed after reset. Configuration is always
// ready.
module graph_reachability_dfs_top #(
	parameter int MAX_VERTICES = grdfs_pkg::MAX_VERTICES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [grdfs_pkg::MODE_W-1:0]      mode,
	input  logic [grdfs_pkg::VTX_W-1:0]       from_vertex,
	input  logic [grdfs_pkg::VTX_W-1:0]       to_vertex,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [grdfs_pkg::MASK_W-1:0]      reached_mask,
	output logic [grdfs_pkg::CNT_W-1:0]       reached_count,
	output logic                              source_invalid,
	output logic                              entry_dropped,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [grdfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [grdfs_pkg::CFG_DATA_W-1:0]  cfg_data
);

	grdfs_pkg::grdfs_cmd_t    cmd;
	grdfs_pkg::grdfs_status_t status;

	assign cfg_ready = 1'b1;

	grdfs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.mode       (mode),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	grdfs_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.from_vertex    (from_vertex),
		.to_vertex      (to_vertex),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.status         (status),
		.result_stall   (result_stall),
		.result_valid   (result_valid),
		.reached_mask   (reached_mask),
		.reached_count  (reached_count),
		.source_invalid (source_invalid),
		.entry_dropped  (entry_dropped)
	);

endmodule

// ===== rtl/grdfs_ram.sv =====
// ----------------------------------------------------------------------------
// grdfs_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module grdfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/grdfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// grdfs_ctrl: sequencing controller
// Takes items, steps adjacency loads and the stack walk of a search, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module grdfs_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  logic [grdfs_pkg::MODE_W-1:0]  mode,
	output logic                          item_stall,
	input  grdfs_pkg::grdfs_status_t      status,
	output grdfs_pkg::grdfs_cmd_t         cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ADD_WR = 3'd1;
	localparam logic [2:0] ST_ADJ    = 3'd2;
	localparam logic [2:0] ST_PUSH   = 3'd3;
	localparam logic [2:0] ST_POP    = 3'd4;
	localparam logic [2:0] ST_STK    = 3'd5;
	localparam logic [2:0] ST_FINISH = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					unique case (mode)
						grdfs_pkg::MODE_ADD: begin
							cmd.start_add = 1'b1;
							if (!status.add_drop) begin
								state_d = ST_ADD_WR;
							end
						end
						grdfs_pkg::MODE_RUN: begin
							cmd.start_run = 1'b1;
							state_d = status.src_bad ? ST_FINISH : ST_ADJ;
						end
						grdfs_pkg::MODE_CLEAR: begin
							cmd.start_clear = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_ADD_WR: begin
				cmd.add_write = 1'b1;
				state_d = ST_IDLE;
			end
			ST_ADJ: begin
				cmd.adj_load = 1'b1;
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				priority if (!status.fresh_zero) begin
					cmd.push = 1'b1;
				end else if (status.depth_zero) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				state_d = ST_STK;
			end
			ST_STK: begin
				cmd.stk_read = 1'b1;
				state_d = ST_ADJ;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/grdfs_dp.sv =====
// ----------------------------------------------------------------------------
// grdfs_dp: search datapath
// Configuration registers, adjacency RAM with row valid bits, vertex stack,
// visited set and result register.
// ----------------------------------------------------------------------------
module grdfs_dp #(
	parameter int MAX_VERTICES = grdfs_pkg::MAX_VERTICES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [grdfs_pkg::VTX_W-1:0]       from_vertex,
	input  logic [grdfs_pkg::VTX_W-1:0]       to_vertex,
	input  logic                              cfg_valid,
	input  logic [grdfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [grdfs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  grdfs_pkg::grdfs_cmd_t             cmd,
	output grdfs_pkg::grdfs_status_t          status,
	input  logic                              result_stall,
	output logic                              result_valid,
	output logic [grdfs_pkg::MASK_W-1:0]      reached_mask,
	output logic [grdfs_pkg::CNT_W-1:0]       reached_count,
	output logic                              source_invalid,
	output logic                              entry_dropped
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int DW = $clog2(MAX_VERTICES + 1);
	localparam logic [MAX_VERTICES-1:0] ONE = MAX_VERTICES'(1);

	logic [grdfs_pkg::CNT_W-1:0] vertex_count_q;
	logic [grdfs_pkg::VTX_W-1:0] source_vertex_q;
	logic [grdfs_pkg::CNT_W-1:0] live_n;
	logic [MAX_VERTICES-1:0]     live;

	logic [MAX_VERTICES-1:0] row_valid_q;
	logic                    drop_q;
	logic [VW-1:0]           from_q;
	logic [VW-1:0]           to_q;
	logic [VW-1:0]           v_q;

	logic [MAX_VERTICES-1:0] visited_q;
	logic [MAX_VERTICES-1:0] fresh_q;
	logic [DW-1:0]           count_q;
	logic [DW-1:0]           depth_q;
	logic                    bad_q;

	logic                    adj_we;
	logic [VW-1:0]           adj_raddr;
	logic                    adj_re;
	logic [MAX_VERTICES-1:0] adj_wdata;
	logic [MAX_VERTICES-1:0] adj_rdata;
	logic [MAX_VERTICES-1:0] add_row;
	logic [MAX_VERTICES-1:0] walk_row;
	logic [MAX_VERTICES-1:0] fresh_d;
	logic [MAX_VERTICES-1:0] low;
	logic [VW-1:0]           push_idx;
	logic [DW-1:0]           depth_m1;
	logic [VW-1:0]           stk_rdata;

	logic                             result_valid_q;
	logic [grdfs_pkg::MASK_W-1:0]     mask_q;
	logic [grdfs_pkg::CNT_W-1:0]      count_out_q;
	logic                             bad_out_q;
	logic                             drop_out_q;

	// effective vertex count and live vertex mask
	assign live_n = (vertex_count_q > grdfs_pkg::CNT_W'(MAX_VERTICES)) ?
		grdfs_pkg::CNT_W'(MAX_VERTICES) : vertex_count_q;

	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			live[i] = (grdfs_pkg::CNT_W'(i) < live_n);
		end
	end

	assign status.add_drop   = ({1'b0, from_vertex} >= live_n) || ({1'b0, to_vertex} >= live_n);
	assign status.src_bad    = ({1'b0, source_vertex_q} >= live_n);
	assign status.fresh_zero = (fresh_q == '0);
	assign status.depth_zero = (depth_q == '0);
	assign status.out_free   = !result_valid_q || !result_stall;

	// adjacency ram access
	assign adj_we = cmd.add_write;
	assign adj_re = cmd.start_add || cmd.start_run || cmd.stk_read;

	always_comb begin
		priority if (cmd.stk_read) begin
			adj_raddr = stk_rdata;
		end else if (cmd.start_run) begin
			adj_raddr = source_vertex_q[VW-1:0];
		end else begin
			adj_raddr = from_vertex[VW-1:0];
		end
	end

	assign add_row   = row_valid_q[from_q] ? adj_rdata : '0;
	assign adj_wdata = add_row | (ONE << to_q);
	assign walk_row  = row_valid_q[v_q] ? adj_rdata : '0;
	assign fresh_d   = walk_row & live & ~visited_q;

	// lowest fresh vertex
	assign low = fresh_q & (~fresh_q + ONE);

	always_comb begin
		push_idx = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			if (low[i]) begin
				push_idx = push_idx | VW'(i);
			end
		end
	end

	assign depth_m1 = depth_q - DW'(1);

	grdfs_ram #(
		.WIDTH (MAX_VERTICES),
		.DEPTH (MAX_VERTICES)
	) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (from_q),
		.wdata (adj_wdata),
		.re    (adj_re),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	grdfs_ram #(
		.WIDTH (VW),
		.DEPTH (MAX_VERTICES)
	) u_stack_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (depth_q[VW-1:0]),
		.wdata (push_idx),
		.re    (cmd.pop),
		.raddr (depth_m1[VW-1:0]),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q  <= grdfs_pkg::VERTEX_COUNT_RST;
			source_vertex_q <= grdfs_pkg::SOURCE_VERTEX_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				grdfs_pkg::CFG_VERTEX_COUNT:  vertex_count_q  <= cfg_data;
				grdfs_pkg::CFG_SOURCE_VERTEX: source_vertex_q <= cfg_data[grdfs_pkg::VTX_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			drop_q      <= 1'b0;
		end else begin
			if (cmd.start_clear) begin
				row_valid_q <= '0;
				drop_q      <= 1'b0;
			end
			if (cmd.start_add && status.add_drop) begin
				drop_q <= 1'b1;
			end
			if (cmd.add_write) begin
				row_valid_q[from_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_add) begin
			from_q <= from_vertex[VW-1:0];
			to_q   <= to_vertex[VW-1:0];
		end
		if (cmd.start_run) begin
			v_q <= source_vertex_q[VW-1:0];
		end else if (cmd.stk_read) begin
			v_q <= stk_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			fresh_q   <= '0;
			count_q   <= '0;
			depth_q   <= '0;
			bad_q     <= 1'b0;
		end else begin
			if (cmd.start_run) begin
				depth_q <= '0;
				fresh_q <= '0;
				bad_q   <= status.src_bad;
				if (status.src_bad) begin
					visited_q <= '0;
					count_q   <= '0;
				end else begin
					visited_q <= ONE << source_vertex_q[VW-1:0];
					count_q   <= DW'(1);
				end
			end
			if (cmd.adj_load) begin
				fresh_q   <= fresh_d;
				visited_q <= visited_q | fresh_d;
			end
			if (cmd.push) begin
				fresh_q <= fresh_q & (fresh_q - ONE);
				depth_q <= depth_q + DW'(1);
				count_q <= count_q + DW'(1);
			end
			if (cmd.pop) begin
				depth_q <= depth_m1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			mask_q      <= grdfs_pkg::MASK_W'(visited_q);
			count_out_q <= grdfs_pkg::CNT_W'(count_q);
			bad_out_q   <= bad_q;
			drop_out_q  <= drop_q;
		end
	end

	assign result_valid   = result_valid_q;
	assign reached_mask   = mask_q;
	assign reached_count  = count_out_q;
	assign source_invalid = bad_out_q;
	assign entry_dropped  = drop_out_q;

endmodule

// ===== rtl/grdfs_checker.sv =====
// ----------------------------------------------------------------------------
// grdfs_checker: port-level checks for the reachability block
// Result consistency and result channel hold, bound to the top level.
// ----------------------------------------------------------------------------
module grdfs_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              result_valid,
	input  logic                              result_stall,
	input  logic [grdfs_pkg::MASK_W-1:0]      reached_mask,
	input  logic [grdfs_pkg::CNT_W-1:0]       reached_count,
	input  logic                              source_invalid,
	input  logic                              entry_dropped
);

	// stalled result transaction holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(reached_mask)
			&& $stable(reached_count) && $stable(source_invalid)
			&& $stable(entry_dropped))
		else $error("stalled result changed");

	// count matches the mask
	a_count_mask: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($countones(reached_mask) == int'(reached_count)))
		else $error("reached count does not match mask");

	// invalid source gives an empty result
	a_bad_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && source_invalid |-> (reached_mask == '0))
		else $error("invalid source with reached vertices");

	// valid source always reaches itself
	a_good_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !source_invalid |-> (reached_count != '0))
		else $error("valid source with empty result");

endmodule

bind graph_reachability_dfs_top grdfs_checker u_grdfs_checker (.*);

// ===== tb/sv/tb_graph_reachability_dfs_top.sv =====
// ----------------------------------------------------------------------------
// tb_graph_reachability_dfs_top: self-checking bench for the graph search block
// Drives add, clear and run transactions through a random-gap driver while a
// scoreboard predicts each search result from its own adjacency matrix copy.
// Phases change vertex count and source while the block is idle, and one phase
// holds off the result side long enough to back up the input channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_graph_reachability_dfs_top;
	import grdfs_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;
	localparam int IDLE_LIMIT    = 4000;

	typedef struct packed {
		logic [MODE_W-1:0] op;
		logic [VTX_W-1:0]  from_v;
		logic [VTX_W-1:0]  to_v;
	} graph_item_t;

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic [CNT_W-1:0]  count;
		logic              invalid;
		logic              dropped;
	} reach_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	logic [MODE_W-1:0]     mode = MODE_ADD;
	logic [VTX_W-1:0]      from_vertex = '0;
	logic [VTX_W-1:0]      to_vertex = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [MASK_W-1:0]     reached_mask;
	logic [CNT_W-1:0]      reached_count;
	logic                  source_invalid;
	logic                  entry_dropped;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// scoreboard copy of the block state
	logic [MASK_W-1:0] adj_rows [MAX_VERTICES_DEF];
	logic              drop_seen;
	logic [CNT_W-1:0]  cfg_count;
	logic [VTX_W-1:0]  cfg_source;

	graph_item_t item_queue [$];
	reach_t      reach_queue [$];
	graph_item_t cur_item;
	reach_t      want;
	int          items_pushed = 0;
	int          items_accepted = 0;
	int          mismatches = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          hold_left = 0;
	int          holds_asked = 0;
	int          holds_served = 0;
	int          idle_cycles = 0;
	bit          no_idle = 1'b0;

	graph_reachability_dfs_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.mode           (mode),
		.from_vertex    (from_vertex),
		.to_vertex      (to_vertex),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.reached_mask   (reached_mask),
		.reached_count  (reached_count),
		.source_invalid (source_invalid),
		.entry_dropped  (entry_dropped),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int eff_count();
		return (cfg_count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(cfg_count);
	endfunction

	function automatic reach_t search_from(input int n);
		logic [MASK_W-1:0] live;
		logic [MASK_W-1:0] seen;
		logic [MASK_W-1:0] fresh;
		logic [VTX_W-1:0]  stack [MAX_VERTICES_DEF];
		int                sp;
		reach_t            r;
		live = (n >= 64) ? '1 : (64'd1 << n) - 64'd1;
		seen = 64'd1 << cfg_source;
		stack[0] = cfg_source;
		sp = 1;
		while (sp > 0) begin
			sp--;
			fresh = adj_rows[stack[sp]] & live & ~seen;
			for (int w = 0; w < MAX_VERTICES_DEF; w++) begin
				if (fresh[w]) begin
					seen[w] = 1'b1;
					stack[sp] = VTX_W'(w);
					sp++;
				end
			end
		end
		r.mask = seen;
		r.count = CNT_W'($countones(seen));
		r.invalid = 1'b0;
		r.dropped = drop_seen;
		return r;
	endfunction

	task automatic apply_item(input graph_item_t it);
		int     n;
		reach_t r;
		n = eff_count();
		case (it.op)
			MODE_ADD: begin
				if (it.from_v >= n || it.to_v >= n)
					drop_seen = 1'b1;
				else
					adj_rows[it.from_v][it.to_v] = 1'b1;
			end
			MODE_CLEAR: begin
				foreach (adj_rows[i])
					adj_rows[i] = '0;
				drop_seen = 1'b0;
			end
			MODE_RUN: begin
				if (cfg_source >= n) begin
					r.mask = '0;
					r.count = '0;
					r.invalid = 1'b1;
					r.dropped = drop_seen;
				end else begin
					r = search_from(n);
				end
				reach_queue.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, exp_val);
		mismatches++;
	endtask

	task automatic queue_item(input logic [MODE_W-1:0] op, input int f, input int t);
		graph_item_t it;
		it.op = op;
		it.from_v = VTX_W'(f);
		it.to_v = VTX_W'(t);
		item_queue.push_back(it);
		items_pushed++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_VERTEX_COUNT)
			cfg_count = val;
		else
			cfg_source = val[VTX_W-1:0];
	endtask

	task automatic wait_idle();
		while (items_accepted != items_pushed || reach_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic pick_config();
		logic [CFG_DATA_W-1:0] cnt;
		logic [CFG_DATA_W-1:0] src;
		int                    n;
		int                    hi;
		case ($urandom_range(0, 9))
			0: cnt = 7'd0;
			1: cnt = 7'd1;
			2: cnt = 7'd64;
			3: cnt = 7'd127;
			4: cnt = CFG_DATA_W'($urandom_range(65, 127));
			default: cnt = CFG_DATA_W'($urandom_range(2, 64));
		endcase
		write_reg(CFG_VERTEX_COUNT, cnt);
		n = eff_count();
		hi = (n < 16) ? n : 16;
		if (n > 0 && $urandom_range(0, 5) != 0)
			src = CFG_DATA_W'($urandom_range(0, hi - 1) | ($urandom_range(0, 1) << 6));
		else
			src = CFG_DATA_W'($urandom_range(0, 127));
		write_reg(CFG_SOURCE_VERTEX, src);
	endtask

	task automatic build_random_phase(input int goal);
		int n;
		int span;
		int k;
		int a;
		int b;
		int queued;
		logic [MODE_W-1:0] op;
		n = eff_count();
		queued = 0;
		while (queued < goal) begin
			if ($urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 2) == 0) begin
					queue_item(MODE_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
					queued++;
				end
				if (n < 2)
					span = 64;
				else if ($urandom_range(0, 3) == 0)
					span = n;
				else
					span = $urandom_range(2, (n < 16) ? n : 16);
				k = $urandom_range(1, 10);
				for (int j = 0; j < k; j++) begin
					a = $urandom_range(0, span - 1);
					b = $urandom_range(0, span - 1);
					queue_item(MODE_ADD, a, b);
					queued++;
					if ($urandom_range(0, 1) == 1) begin
						queue_item(MODE_ADD, b, a);
						queued++;
					end
				end
				queue_item(MODE_RUN, $urandom_range(0, 63), $urandom_range(0, 63));
				queued++;
			end else begin
				op = MODE_W'($urandom_range(0, 3));
				queue_item(op, $urandom_range(0, 63), $urandom_range(0, 63));
				if (op != MODE_UNUSED)
					queued++;
			end
		end
	endtask

	// item driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (item_valid && !item_stall) begin
				apply_item(cur_item);
				items_accepted++;
			end
			if (!item_valid || !item_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (!no_idle && $urandom_range(0, 5) == 0) begin
					gap_left = $urandom_range(1, 17) - 1;
					item_valid <= 1'b0;
				end else if (item_queue.size() > 0) begin
					cur_item = item_queue.pop_front();
					item_valid <= 1'b1;
					mode <= cur_item.op;
					from_vertex <= cur_item.from_v;
					to_vertex <= cur_item.to_v;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// result stall generator
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (holds_served != holds_asked) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 17) - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (reach_queue.size() == 0) begin
				report_mismatch("unexpected result transaction", reached_mask, 64'd0);
			end else begin
				want = reach_queue.pop_front();
				if (reached_mask !== want.mask)
					report_mismatch("reached_mask", reached_mask, want.mask);
				if (reached_count !== want.count)
					report_mismatch("reached_count", 64'(reached_count), 64'(want.count));
				if (source_invalid !== want.invalid)
					report_mismatch("source_invalid", 64'(source_invalid), 64'(want.invalid));
				if (entry_dropped !== want.dropped)
					report_mismatch("entry_dropped", 64'(entry_dropped), 64'(want.dropped));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)
					|| (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
				$display("tb_graph_reachability_dfs_top: FAIL");
				$finish;
			end
		end
	end

	initial begin
		foreach (adj_rows[i])
			adj_rows[i] = '0;
		drop_seen = 1'b0;
		cfg_count = VERTEX_COUNT_RST;
		cfg_source = SOURCE_VERTEX_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: empty graph, cycle through both ends, self loop
		queue_item(MODE_RUN, 0, 0);
		queue_item(MODE_ADD, 0, 63);
		queue_item(MODE_ADD, 63, 1);
		queue_item(MODE_ADD, 1, 0);
		queue_item(MODE_ADD, 5, 5);
		queue_item(MODE_UNUSED, 63, 63);
		queue_item(MODE_RUN, 63, 63);
		queue_item(MODE_CLEAR, 42, 21);
		queue_item(MODE_RUN, 0, 0);
		wait_idle();

		// dropped entries and a clear of the drop flag
		write_reg(CFG_VERTEX_COUNT, 7'd10);
		write_reg(CFG_SOURCE_VERTEX, 7'd9);
		queue_item(MODE_ADD, 9, 3);
		queue_item(MODE_ADD, 3, 12);
		queue_item(MODE_ADD, 63, 0);
		queue_item(MODE_RUN, 0, 0);
		queue_item(MODE_CLEAR, 0, 0);
		queue_item(MODE_RUN, 0, 0);
		wait_idle();

		// zero vertices
		write_reg(CFG_VERTEX_COUNT, 7'd0);
		write_reg(CFG_SOURCE_VERTEX, 7'd0);
		queue_item(MODE_RUN, 0, 0);
		queue_item(MODE_ADD, 0, 0);
		queue_item(MODE_RUN, 0, 0);
		wait_idle();

		// saturated count, top source
		write_reg(CFG_VERTEX_COUNT, 7'd127);
		write_reg(CFG_SOURCE_VERTEX, 7'd127);
		queue_item(MODE_CLEAR, 63, 63);
		queue_item(MODE_ADD, 63, 62);
		queue_item(MODE_ADD, 62, 0);
		queue_item(MODE_RUN, 0, 0);
		wait_idle();

		// count lowered below loaded vertices
		write_reg(CFG_VERTEX_COUNT, 7'd63);
		write_reg(CFG_SOURCE_VERTEX, 7'd62);
		queue_item(MODE_ADD, 0, 63);
		queue_item(MODE_RUN, 0, 0);
		wait_idle();
		write_reg(CFG_VERTEX_COUNT, 7'd5);
		write_reg(CFG_SOURCE_VERTEX, 7'd5);
		queue_item(MODE_RUN, 0, 0);
		wait_idle();

		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 9)
				no_idle = 1'b1;
			pick_config();
			if (ph == 3)
				holds_asked++;
			build_random_phase(50);
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb_graph_reachability_dfs_top: PASS");
		else
			$display("tb_graph_reachability_dfs_top: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/grdfs_pkg.sv
rtl/grdfs_ram.sv
rtl/grdfs_ctrl.sv
rtl/grdfs_dp.sv
rtl/graph_reachability_dfs_top.sv
rtl/grdfs_checker.sv
tb/sv/tb_graph_reachability_dfs_top.sv
